FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KST_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define KST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Payload types and command codes of the keyed sorted score table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned RankW  = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned ScoreW = 32;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [KeyW-1:0]          player_id;
    logic signed [ScoreW-1:0] new_score;
    logic [RankW-1:0]         read_rank;
  } kst_req_t;

  typedef struct packed {
    logic [RankW-1:0]         rank;
    logic [KeyW-1:0]          entry_key;
    logic signed [ScoreW-1:0] entry_score;
    logic                     entry_valid;
    logic [CountW-1:0]        entry_count;
    logic                     dropped;
  } kst_rsp_t;

endpackage

FILE: rtl/core/kst_stream_if.sv
// ----------------------------------------------------------------------------
// kst_req_if / kst_rsp_if
// Valid/ready channels of the score table: command in, result out.
// ----------------------------------------------------------------------------
interface kst_req_if;
  logic              valid;
  logic              ready;
  kst_pkg::kst_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface kst_rsp_if;
  logic              valid;
  logic              ready;
  kst_pkg::kst_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/keyed_sorted_score_table.sv
// ----------------------------------------------------------------------------
// keyed_sorted_score_table
// Keeps up to TABLE_DEPTH (key, signed score) entries ordered by descending
// score, equal scores in their earlier order. A set updates or appends a key
// and reports its new rank; a read returns the entry at a rank. A new key on
// a full table is refused with dropped set. The table starts empty. A read
// goes from the memory read through ST_READ and ST_FINISH. A set searches
// all n entries in ST_SCAN, then in ST_MOVE walks the span between F, the
// old place of the key (n for a new key), and P, its new rank, one entry a
// cycle, then writes the key in ST_PLACE; the single read port of the entry
// memory sets this pace. One item is worked on at a time, and the next one
// transfers in only once the last has gone from ST_FINISH to its result
// register; that register lets it transfer in while a result still waits.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module keyed_sorted_score_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kst_req_if.sink   in_i,
  kst_rsp_if.source out_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);      // entry index
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);  // entry count
  localparam int unsigned AW = (CW > kst_pkg::CountW) ? CW : kst_pkg::CountW;
  localparam int unsigned XW = (KEY_BITS > kst_pkg::KeyW) ? KEY_BITS : kst_pkg::KeyW;
  localparam int unsigned SW = kst_pkg::ScoreW;
  localparam int unsigned WW = KEY_BITS + SW;            // memory word
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_PLACE,
    ST_READ,
    ST_FINISH
  } state_e;

  // Entry memory: key in the upper bits, score in the lower 32.
  logic [WW-1:0] entry_mem [TABLE_DEPTH];
  logic [WW-1:0] rd_data_q;
  logic          mem_rd_en;
  logic [IW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  logic [WW-1:0] mem_wr_data;

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      entry_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_q <= entry_mem[mem_rd_addr];
    end
  end

  // Control and item state
  state_e                state_q, state_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic signed [SW-1:0]  score_q, score_d;
  logic [CW-1:0]         count_q, count_d;       // entries held
  logic [CW-1:0]         scan_idx_q, scan_idx_d; // next address of the search
  logic                  cmp_vld_q, cmp_vld_d;   // rd_data_q holds a searched entry
  logic [IW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                  found_q, found_d;
  logic [IW-1:0]         fidx_q, fidx_d;         // old place of the key
  logic [CW-1:0]         pos_q, pos_d;           // new rank of the key
  logic [CW-1:0]         mv_left_q, mv_left_d;
  logic [IW-1:0]         mv_src_q, mv_src_d;
  logic                  mv_down_q, mv_down_d;   // entries shift to higher ranks
  logic                  wr_pend_q, wr_pend_d;
  logic [IW-1:0]         wr_addr_q, wr_addr_d;
  logic                  rd_vld_q, rd_vld_d;     // read rank lies below count
  logic [kst_pkg::RankW-1:0] rr_q, rr_d;
  kst_pkg::kst_rsp_t     res_q, res_d;
  kst_pkg::kst_rsp_t     out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  // Width adaptation
  logic [XW-1:0]         in_key_ext;
  logic [XW-1:0]         key_ext;
  logic [XW-1:0]         rd_key_ext;
  logic [KEY_BITS-1:0]   rd_key;
  logic signed [SW-1:0]  rd_score;
  logic [AW-1:0]         rr_ext;
  logic [AW-1:0]         cnt_ext;
  logic [AW-1:0]         pos_ext;
  logic                  issue;
  logic [CW-1:0]         fidx_full;
  logic [CW-1:0]         src_dn;
  logic [CW-1:0]         src_up;

  assign in_key_ext = XW'(in_i.payload.player_id);
  assign key_ext    = XW'(key_q);
  assign rd_key     = rd_data_q[WW-1:SW];
  assign rd_key_ext = XW'(rd_key);
  assign rd_score   = signed'(rd_data_q[SW-1:0]);
  assign rr_ext     = AW'(in_i.payload.read_rank);
  assign cnt_ext    = AW'(count_q);
  assign pos_ext    = AW'(pos_q);
  assign issue      = (scan_idx_q < count_q);
  assign fidx_full  = found_q ? CW'(fidx_q) : count_q;
  assign src_dn     = fidx_full - CW'(1);
  assign src_up     = fidx_full + CW'(1);

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    score_d     = score_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    pos_d       = pos_q;
    mv_left_d   = mv_left_q;
    mv_src_d    = mv_src_q;
    mv_down_d   = mv_down_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    rd_vld_d    = rd_vld_q;
    rr_d        = rr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          key_d   = in_key_ext[KEY_BITS-1:0];
          score_d = in_i.payload.new_score;
          if (in_i.payload.command == kst_pkg::CMD_READ) begin
            rr_d        = in_i.payload.read_rank;
            rd_vld_d    = (rr_ext < cnt_ext);
            mem_rd_en   = rd_vld_d;
            mem_rd_addr = rr_ext[IW-1:0];
            state_d     = ST_READ;
          end else begin
            scan_idx_d = '0;
            found_d    = 1'b0;
            pos_d      = '0;
            state_d    = ST_SCAN;
          end
        end
      end

      ST_READ: begin
        res_d.rank        = rr_q;
        res_d.entry_key   = rd_vld_q ? rd_key_ext[kst_pkg::KeyW-1:0] : '0;
        res_d.entry_score = rd_vld_q ? rd_score : '0;
        res_d.entry_valid = rd_vld_q;
        res_d.entry_count = cnt_ext[kst_pkg::CountW-1:0];
        res_d.dropped     = 1'b0;
        state_d           = ST_FINISH;
      end

      ST_SCAN: begin
        // Search for the key and count the entries that stay ahead of it:
        // higher scores, and equal scores that sit before its old place.
        if (issue) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = scan_idx_q[IW-1:0];
          scan_idx_d  = scan_idx_q + CW'(1);
        end
        cmp_vld_d = issue;
        cmp_idx_d = scan_idx_q[IW-1:0];
        if (cmp_vld_q) begin
          if (rd_key == key_q && !found_q) begin
            found_d = 1'b1;
            fidx_d  = cmp_idx_q;
          end else if (rd_score > score_q || (rd_score == score_q && !found_q)) begin
            pos_d = pos_q + CW'(1);
          end
        end
        if (!issue && !cmp_vld_q) begin
          if (!found_q && count_q == DepthC) begin
            res_d             = '0;
            res_d.entry_count = cnt_ext[kst_pkg::CountW-1:0];
            res_d.dropped     = 1'b1;
            state_d           = ST_FINISH;
          end else begin
            if (!found_q) begin
              count_d = count_q + CW'(1);
            end
            fidx_d    = fidx_full[IW-1:0];
            mv_down_d = (pos_q < fidx_full);
            mv_left_d = (pos_q < fidx_full) ? (fidx_full - pos_q) : (pos_q - fidx_full);
            mv_src_d  = (pos_q < fidx_full) ? src_dn[IW-1:0] : src_up[IW-1:0];
            state_d   = ST_MOVE;
          end
        end
      end

      ST_MOVE: begin
        // Shift the entries between old place and new rank by one;
        // each write lands in the cycle after its read.
        if (wr_pend_q) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_addr_q;
          mem_wr_data = rd_data_q;
        end
        if (mv_left_q != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = mv_src_q;
          mv_left_d   = mv_left_q - CW'(1);
          mv_src_d    = mv_down_q ? (mv_src_q - IW'(1)) : (mv_src_q + IW'(1));
          wr_pend_d   = 1'b1;
          wr_addr_d   = mv_down_q ? (mv_src_q + IW'(1)) : (mv_src_q - IW'(1));
        end else if (!wr_pend_q) begin
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        mem_wr_en         = 1'b1;
        mem_wr_addr       = pos_q[IW-1:0];
        mem_wr_data       = {key_q, score_q};
        res_d.rank        = pos_ext[kst_pkg::RankW-1:0];
        res_d.entry_key   = key_ext[kst_pkg::KeyW-1:0];
        res_d.entry_score = score_q;
        res_d.entry_valid = 1'b1;
        res_d.entry_count = cnt_ext[kst_pkg::CountW-1:0];
        res_d.dropped     = 1'b0;
        state_d           = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_vld_q   <= cmp_vld_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    score_q    <= score_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    found_q    <= found_d;
    fidx_q     <= fidx_d;
    pos_q      <= pos_d;
    mv_left_q  <= mv_left_d;
    mv_src_q   <= mv_src_d;
    mv_down_q  <= mv_down_d;
    wr_addr_q  <= wr_addr_d;
    rd_vld_q   <= rd_vld_d;
    rr_q       <= rr_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

FILE: rtl/core/kst_checker.sv
// ----------------------------------------------------------------------------
// kst_checker
// Port-level checks of the score table, bound into the score table module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kst_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input kst_pkg::kst_rsp_t out_data_i
);

  logic [kst_pkg::CountW-1:0] last_count_q;
  logic [1:0]                 pending_q;
  logic                       in_xfer;
  logic                       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Items taken in but not yet answered, and the count of the last result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      pending_q    <= '0;
    end else begin
      if (out_xfer) begin
        last_count_q <= out_data_i.entry_count;
      end
      if (in_xfer && !out_xfer) begin
        pending_q <= pending_q + 2'd1;
      end else if (!in_xfer && out_xfer) begin
        pending_q <= pending_q - 2'd1;
      end
    end
  end

  `KST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  `KST_ASSERT_IMPL(a_count_step, clk_i, rst_ni, out_valid_i, (out_data_i.entry_count == last_count_q) || (out_data_i.entry_count == last_count_q + 7'd1))
  `KST_ASSERT_IMPL(a_drop_clean, clk_i, rst_ni, out_valid_i && out_data_i.dropped, !out_data_i.entry_valid && (out_data_i.entry_count == last_count_q))
  `KST_ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, out_valid_i, pending_q != 2'd0)

endmodule

bind keyed_sorted_score_table kst_checker u_kst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);

FILE: dv/tb_keyed_sorted_score_table.sv
// ----------------------------------------------------------------------------
// tb_keyed_sorted_score_table
// Self-checking bench for the sorted score table. A built-in copy of the
// table (keys, scores, fill level) works out the result of every command at
// the moment it transfers in. A monitor compares each result transfer with
// the oldest pending prediction, field by field. Stimulus: directed corner
// commands, then random traffic on a partly filled table, a fill up to the
// overflow point, and random traffic on the full table. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_keyed_sorted_score_table;

  localparam int unsigned RankW  = kst_pkg::RankW;
  localparam int unsigned CountW = kst_pkg::CountW;
  localparam int unsigned KeyW   = kst_pkg::KeyW;
  localparam int unsigned ScoreW = kst_pkg::ScoreW;

  localparam int unsigned TblDepth = 64;
  localparam int unsigned KeyBits  = 16;
  // A set walks all n entries plus the move span.
  localparam int unsigned SettleCycles = 2 * TblDepth + 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  kst_req_if req_if ();
  kst_rsp_if rsp_if ();

  keyed_sorted_score_table #(
    .TABLE_DEPTH(TblDepth),
    .KEY_BITS   (KeyBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Table predictor: a private copy of the entries, kept in rank order.
  // --------------------------------------------------------------------------
  logic [KeyW-1:0]          tbl_key   [TblDepth];
  logic signed [ScoreW-1:0] tbl_score [TblDepth];
  int unsigned              tbl_used = 0;

  kst_pkg::kst_rsp_t pending_results [$];
  int unsigned mismatches = 0;

  function automatic bit key_present(input logic [KeyW-1:0] k);
    for (int unsigned i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one command to the table copy and returns the result it owes.
  function automatic kst_pkg::kst_rsp_t score_table_step(input kst_pkg::kst_req_t item);
    kst_pkg::kst_rsp_t        res;
    logic [KeyW-1:0]          k;
    logic signed [ScoreW-1:0] s;
    int                       j;
    bit                       hit;

    res = '0;
    hit = 1'b0;
    if (item.command == kst_pkg::CMD_READ) begin
      // Reads past the fill level come back invalid with zero payload.
      res.rank = item.read_rank;
      if (item.read_rank < tbl_used) begin
        res.entry_key   = tbl_key[item.read_rank];
        res.entry_score = tbl_score[item.read_rank];
        res.entry_valid = 1'b1;
      end
      res.entry_count = CountW'(tbl_used);
      return res;
    end

    // Known key: overwrite its score in place.
    for (int unsigned i = 0; i < tbl_used; i++) begin
      if (!hit && tbl_key[i] == item.player_id) begin
        tbl_score[i] = item.new_score;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      // New key on a full table: refused, table untouched.
      if (tbl_used >= TblDepth) begin
        res.dropped     = 1'b1;
        res.entry_count = CountW'(tbl_used);
        return res;
      end
      tbl_key[tbl_used]   = item.player_id;
      tbl_score[tbl_used] = item.new_score;
      tbl_used++;
    end

    // Stable reorder by descending score; only a strictly higher score
    // overtakes, so ties keep their earlier order.
    for (int i = 1; i < int'(tbl_used); i++) begin
      k = tbl_key[i];
      s = tbl_score[i];
      j = i - 1;
      while (j >= 0 && tbl_score[j] < s) begin
        tbl_key[j+1]   = tbl_key[j];
        tbl_score[j+1] = tbl_score[j];
        j--;
      end
      tbl_key[j+1]   = k;
      tbl_score[j+1] = s;
    end

    for (int unsigned i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == item.player_id) begin
        res.rank        = RankW'(i);
        res.entry_key   = tbl_key[i];
        res.entry_score = tbl_score[i];
        res.entry_valid = 1'b1;
      end
    end
    res.entry_count = CountW'(tbl_used);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v) begin
      report_mismatch($sformatf("%s got %h, predicted %h", name, got, want_v));
    end
  endtask

  // Samples at the edge, before any update of that edge lands.
  always @(posedge clk_i) begin : result_check
    kst_pkg::kst_rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no prediction pending");
      end else begin
        want = pending_results.pop_front();
        check_field("rank",        rsp_if.payload.rank,        want.rank);
        check_field("entry_key",   rsp_if.payload.entry_key,   want.entry_key);
        check_field("entry_score", rsp_if.payload.entry_score, want.entry_score);
        check_field("entry_valid", rsp_if.payload.entry_valid, want.entry_valid);
        check_field("entry_count", rsp_if.payload.entry_count, want.entry_count);
        check_field("dropped",     rsp_if.payload.dropped,     want.dropped);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle lengths: mostly short, now and then a long one.
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 15) < 13) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Result side: random stalls, with stretches of steady ready.
  int unsigned stall_left = 0;
  int unsigned rsp_mode_left = 0;
  bit          rsp_burst = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_mode_left == 0) begin
        rsp_mode_left <= $urandom_range(50, 300);
        rsp_burst     <= ($urandom_range(0, 2) == 0);
      end else begin
        rsp_mode_left <= rsp_mode_left - 1;
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!rsp_burst && $urandom_range(0, 3) == 0) begin
        stall_left   <= idle_len() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  bit          send_burst = 1'b0;
  int unsigned send_burst_left = 0;

  // One command transfer. Valid stays high into the next command when no
  // gap follows, so it never gets two updates in one step.
  task automatic send_item(input kst_pkg::kst_req_t item);
    int unsigned       gap;
    kst_pkg::kst_rsp_t predicted;
    gap = 0;
    if (send_burst_left == 0) begin
      send_burst      = ($urandom_range(0, 3) == 0);
      send_burst_left = $urandom_range(20, 80);
    end else begin
      send_burst_left--;
    end
    if (!send_burst && $urandom_range(0, 1) == 0) gap = idle_len();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= item;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted = score_table_step(item);
    pending_results.insert(pending_results.size(), predicted);
  endtask

  // Set command; the unused rank field carries noise.
  task automatic send_set(input logic [KeyW-1:0] k, input logic signed [ScoreW-1:0] s);
    kst_pkg::kst_req_t item;
    item.command   = kst_pkg::CMD_SET;
    item.player_id = k;
    item.new_score = s;
    item.read_rank = RankW'($urandom_range(0, 63));
    send_item(item);
  endtask

  // Read command; the unused key and score fields carry noise.
  task automatic send_read(input logic [RankW-1:0] r);
    kst_pkg::kst_req_t item;
    item.command   = kst_pkg::CMD_READ;
    item.player_id = KeyW'($urandom_range(0, 65535));
    item.new_score = $urandom;
    item.read_rank = r;
    send_item(item);
  endtask

  // Holds the command side until every predicted result has come back.
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Scores: many near zero to force ties, some extremes, the rest anywhere.
  function automatic logic signed [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 7))
      0, 1, 2: return int'($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] fresh_key();
    logic [KeyW-1:0] k;
    k = KeyW'($urandom_range(0, 65535));
    while (key_present(k)) k = KeyW'($urandom_range(0, 65535));
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty-table reads, key and score extremes, ties and in-place updates.
  task automatic test_corner_items();
    send_read(6'd0);                       // empty table
    send_read(6'd63);
    send_set(16'h0000, 32'sd0);
    send_set(16'hFFFF, 32'sh7FFF_FFFF);    // max score takes rank 0
    send_set(16'h8000, 32'sh8000_0000);    // min score at the tail
    send_set(16'h1234, 32'sd0);            // tie, lands after key 0
    send_set(16'h0000, 32'sd0);            // same score again
    send_set(16'h8000, 32'sh7FFF_FFFF);    // ties max, stays behind 0xFFFF
    send_set(16'hFFFF, 32'sh8000_0000);    // top entry falls to the end
    send_set(16'h1234, 32'sd1);            // overtakes its tie partner
    send_set(16'h5555, -32'sd1);
    send_set(16'hAAAA, -32'sd1);
    for (int unsigned r = 0; r < 8; r++) send_read(RankW'(r));  // past count too
    send_read(6'd63);
  endtask

  // Random mix on a table kept below about forty entries.
  task automatic test_random_partial(input int unsigned n_items);
    int unsigned pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_read(RankW'($urandom_range(0, 63)));
      end else if (tbl_used != 0 && (pick < 70 || tbl_used >= 40)) begin
        send_set(tbl_key[$urandom_range(0, tbl_used - 1)], pick_score());
      end else begin
        send_set(KeyW'($urandom_range(0, 65535)), pick_score());
      end
    end
  endtask

  // Fill to capacity, then new keys must be refused.
  task automatic test_fill_and_overflow();
    while (tbl_used < TblDepth) send_set(fresh_key(), pick_score());
    repeat (4) send_set(fresh_key(), pick_score());
    send_set(tbl_key[TblDepth - 1], 32'sh7FFF_FFFF);
    send_set(tbl_key[0], 32'sh8000_0000);
    send_read(6'd63);
    send_read(6'd0);
  endtask

  // Random mix on the full table: updates, refusals and reads.
  task automatic test_random_full(input int unsigned n_items);
    int unsigned pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      send_read(RankW'($urandom_range(0, 63)));
      else if (pick < 80) send_set(tbl_key[$urandom_range(0, tbl_used - 1)], pick_score());
      else                send_set(fresh_key(), pick_score());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corner_items();
    test_random_partial(420);
    wait_results_drained();
    test_fill_and_overflow();
    test_random_full(290);
    wait_results_drained();
    test_random_full(290);

    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_stream_if.sv
rtl/core/keyed_sorted_score_table.sv
rtl/core/kst_checker.sv
dv/tb_keyed_sorted_score_table.sv
